// ----- design/ols_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ols_pkg
// Shared types and constants for the ordered list store.
// ----------------------------------------------------------------------------
package ols_pkg;
  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int LEN_W = 7;

  localparam logic [2:0] REQ_APPEND = 3'd0;
  localparam logic [2:0] REQ_SEARCH = 3'd1;
  localparam logic [2:0] REQ_COUNT  = 3'd2;
  localparam logic [2:0] REQ_REMOVE = 3'd3;
  localparam logic [2:0] REQ_INSERT = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_TOO_SMALL = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // Per-cycle command to the cells: shift and value are shared, load_in is per cell.
  typedef struct packed {
    logic        shift;    // each cell not loading takes its next neighbor's value (cell k takes k+1)
    logic        load_in;  // the selected cell takes the new value; load wins over shift
    logic [31:0] value;
  } ols_cmd_t;
endpackage

// ----- design/ols_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ols_cell
// One storage cell of the rotating chain: holds one word, passes it on.
// ----------------------------------------------------------------------------
module ols_cell (
  input  logic                 clk,
  input  ols_pkg::ols_cmd_t    cmd,
  input  logic [31:0]          prev_value,
  output logic [31:0]          value
);
  logic [31:0] value_r;
  logic [31:0] value_nxt;

  always_comb begin
    value_nxt = value_r;
    if (cmd.load_in) begin
      value_nxt = cmd.value;
    end else if (cmd.shift) begin
      value_nxt = prev_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;
endmodule

// ----- design/ordered_list_store.sv -----
`timescale 1ns / 1ps
// Timing: search/count/remove visit each held entry in S_SCAN and then answer from
//   S_DONE; append/insert also load the new word during the scan. Full, bad-position and
//   unused-type requests answer in the cycle after accept. Earlier search matches go out as found.
// Throughput: sequential; the next request can be taken in the cycle after the final word is
//   loaded, unless the output stalls; back-to-back for immediate answers.
// Reset: rst_n synchronous active low clears length, control and output valid; cell
//   contents are not reset and only entries below the length are ever read.
// ----------------------------------------------------------------------------
// ordered_list_store
// Ordered list held as a queue in a chain of cells, head in cell 0. A scanning
// request visits every stored word once: the head word leaves, is examined, and is
// either loaded back at the queue tail (kept) or dropped. An insert loads the
// new word at the tail when the words in front of it have been visited. After
// all original words are visited the queue is back in order with the edit.
// ----------------------------------------------------------------------------
module ordered_list_store (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic signed [31:0] in_value,
  input  logic [6:0]  in_position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [6:0]  out_match_position,
  output logic [6:0]  out_match_count,
  output logic        out_last
);
  localparam int N  = ols_pkg::MAX_ENTRIES;
  localparam int LW = ols_pkg::LEN_W;
  localparam int IW = ols_pkg::IDX_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [LW-1:0] len_r, len_nxt;       // words currently in the queue
  logic [LW-1:0] orig_r, orig_nxt;     // length at request start
  logic [LW-1:0] vis_r, vis_nxt;       // original words visited so far
  logic [2:0]    req_r, req_nxt;
  logic [31:0]   key_r, key_nxt;
  logic [LW-1:0] pos_r, pos_nxt;       // insert position (append: length + 1)
  logic          ins_pend_r, ins_pend_nxt;
  logic          seen_r, seen_nxt;
  logic          found_r, found_nxt;
  logic [LW-1:0] mpos_r, mpos_nxt;     // held-back search match, sent when next is known
  logic [LW-1:0] cnt_r, cnt_nxt;

  logic          ov_r, ov_nxt;
  logic [1:0]    os_r, os_nxt;
  logic [LW-1:0] op_r, op_nxt, oc_r, oc_nxt;
  logic          ol_r, ol_nxt;

  logic [31:0]   cell_v [N];
  logic [31:0]   cell_next [N];
  logic          ring_shift;
  logic          ring_load;
  logic [IW-1:0] load_idx;
  logic [31:0]   load_val;

  // Chain: cell k takes cell k+1 on a shift; one selected cell loads instead.
  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      ols_pkg::ols_cmd_t c;
      assign c = '{shift: ring_shift,
                   load_in: ring_load && (load_idx == IW'(g)),
                   value: load_val};
      if (g == N - 1) begin : g_tail
        assign cell_next[g] = '0;
      end else begin : g_mid
        assign cell_next[g] = cell_v[g+1];
      end
      ols_cell u_cell (.clk(clk), .cmd(c), .prev_value(cell_next[g]),
                       .value(cell_v[g]));
    end
  endgenerate

  logic out_free;
  assign out_free = !ov_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign out_valid = ov_r;
  assign out_status = os_r;
  assign out_match_position = op_r;
  assign out_match_count = oc_r;
  assign out_last = ol_r;

  logic        in_acc;
  logic [31:0] head;
  logic        hit;
  logic        ins_here;
  logic        pop_go;

  assign in_acc = in_valid && !in_stall;
  assign head = cell_v[0];
  assign hit = (head == key_r);
  assign ins_here = ins_pend_r && (vis_r == pos_r - LW'(1));
  // A search hit with a match already held must hand that one to the output first.
  assign pop_go = !(req_r == ols_pkg::REQ_SEARCH && hit && found_r) || out_free;

  always_comb begin
    state_nxt = state_r;
    len_nxt = len_r;
    orig_nxt = orig_r;
    vis_nxt = vis_r;
    req_nxt = req_r;
    key_nxt = key_r;
    pos_nxt = pos_r;
    ins_pend_nxt = ins_pend_r;
    seen_nxt = seen_r;
    found_nxt = found_r;
    mpos_nxt = mpos_r;
    cnt_nxt = cnt_r;
    ov_nxt = ov_r && out_stall;
    os_nxt = os_r;
    op_nxt = op_r;
    oc_nxt = oc_r;
    ol_nxt = ol_r;
    ring_shift = 1'b0;
    ring_load = 1'b0;
    load_idx = '0;
    load_val = head;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_nxt = in_req_type;
          key_nxt = in_value;
          pos_nxt = in_position;
          orig_nxt = len_r;
          vis_nxt = '0;
          seen_nxt = 1'b0;
          found_nxt = 1'b0;
          mpos_nxt = '0;
          cnt_nxt = '0;
          ins_pend_nxt = 1'b0;
          if (in_req_type == ols_pkg::REQ_APPEND ||
              in_req_type == ols_pkg::REQ_INSERT) begin
            // full check comes before the position check
            if (len_r >= LW'(N)) begin
              ov_nxt = 1'b1; os_nxt = ols_pkg::ST_FULL;
              op_nxt = '0; oc_nxt = '0; ol_nxt = 1'b1;
            end else if (in_req_type == ols_pkg::REQ_INSERT &&
                         (in_position == 7'd0 || in_position > len_r + LW'(1))) begin
              ov_nxt = 1'b1; os_nxt = ols_pkg::ST_TOO_SMALL;
              op_nxt = '0; oc_nxt = '0; ol_nxt = 1'b1;
            end else begin
              state_nxt = S_SCAN;
              ins_pend_nxt = 1'b1;
              if (in_req_type == ols_pkg::REQ_APPEND) pos_nxt = len_r + LW'(1);
            end
          end else if (in_req_type == ols_pkg::REQ_SEARCH ||
                       in_req_type == ols_pkg::REQ_COUNT ||
                       in_req_type == ols_pkg::REQ_REMOVE) begin
            state_nxt = S_SCAN;
          end else begin
            // unused request type: plain ok word
            ov_nxt = 1'b1; os_nxt = ols_pkg::ST_OK;
            op_nxt = '0; oc_nxt = '0; ol_nxt = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (ins_here) begin
          // new word joins the queue tail; the head holds this cycle
          ring_load = 1'b1;
          load_idx = IW'(len_r);
          load_val = key_r;
          len_nxt = len_r + LW'(1);
          ins_pend_nxt = 1'b0;
        end else if (vis_r < orig_r) begin
          if (pop_go) begin
            ring_shift = 1'b1;
            ring_load = 1'b1;
            load_idx = IW'(len_r - LW'(1));
            vis_nxt = vis_r + LW'(1);
            unique case (req_r)
              ols_pkg::REQ_SEARCH: begin
                if (hit) begin
                  if (found_r) begin
                    ov_nxt = 1'b1; os_nxt = ols_pkg::ST_OK;
                    op_nxt = mpos_r; oc_nxt = '0; ol_nxt = 1'b0;
                  end
                  found_nxt = 1'b1;
                  mpos_nxt = vis_r + LW'(1);
                end
              end
              ols_pkg::REQ_COUNT: begin
                if (hit) cnt_nxt = cnt_r + LW'(1);
              end
              ols_pkg::REQ_REMOVE: begin
                if (hit) begin
                  if (seen_r) begin
                    // later duplicate: not loaded back, queue shrinks
                    ring_load = 1'b0;
                    len_nxt = len_r - LW'(1);
                  end
                  seen_nxt = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
          ov_nxt = 1'b1; op_nxt = '0; oc_nxt = '0; ol_nxt = 1'b1;
          os_nxt = ols_pkg::ST_OK;
          unique case (req_r)
            ols_pkg::REQ_SEARCH: begin
              if (found_r) op_nxt = mpos_r;
              else os_nxt = ols_pkg::ST_NOT_FOUND;
            end
            ols_pkg::REQ_COUNT: begin
              oc_nxt = cnt_r;
              if (cnt_r == '0) os_nxt = ols_pkg::ST_NOT_FOUND;
            end
            default: ;
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r <= len_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    orig_r <= orig_nxt;
    vis_r <= vis_nxt;
    req_r <= req_nxt;
    key_r <= key_nxt;
    pos_r <= pos_nxt;
    ins_pend_r <= ins_pend_nxt;
    seen_r <= seen_nxt;
    found_r <= found_nxt;
    mpos_r <= mpos_nxt;
    cnt_r <= cnt_nxt;
    os_r <= os_nxt;
    op_r <= op_nxt;
    oc_r <= oc_nxt;
    ol_r <= ol_nxt;
  end
endmodule
